FILE: hdl/running_average_background_model_macros.svh
// assertion macros for the background model checker
`ifndef RUNNING_AVERAGE_BACKGROUND_MODEL_MACROS_SVH
`define RUNNING_AVERAGE_BACKGROUND_MODEL_MACROS_SVH

// same-cycle implication
`define RABM_ASSERT_IMPL(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RABM_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/rabm_pkg.sv
package rabm_pkg;

  localparam int FRAME_WIDTH  = 640;
  localparam int FRAME_HEIGHT = 480;
  localparam int COUNT_BITS   = 16;

  localparam int PIXELS    = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int ADDR_W    = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int DIV_W     = COUNT_BITS + 1;
  localparam int CMP_W     = (DIV_W > 9) ? DIV_W : 9;
  localparam int MEM_W     = 24 + COUNT_BITS;
  localparam int DIV_STEPS = 8;

  localparam logic [9:0] THR_RESET = 10'd300;
  localparam logic [7:0] GRAY      = 8'd128;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef logic [2:0][7:0] rgb_t;
  typedef logic [COUNT_BITS-1:0] cnt_t;

  // item state that rides along the divider
  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] addr;
    logic              on_frame;
    logic              in_box;
    logic              wr;
    logic              avg;
    logic [2:0]        neg;
    rgb_t              bkg;
    cnt_t              cnt;
  } side_t;

  // one divider stage: dividend, quotient, remainder per channel
  typedef struct packed {
    rgb_t             dvd;
    rgb_t             quo;
    rgb_t             rem;
    logic [DIV_W-1:0] dvs;
    side_t            side;
  } div_stage_t;

endpackage

FILE: hdl/running_average_background_model.sv
// pipeline: read stage register and memory read, divider entry register, divider steps, output register
// throughput: one pixel per cycle unless the output stalls; a pixel whose entry is still in
//   flight waits until the read-modify-write through the 8-step divider pipeline is done
// reset: clears pipeline valids, the frame counter and sets diff_threshold to 300;
//   the background and count memories are not cleared and must be written by an init frame
module running_average_background_model (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [9:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       kind,
  input  logic       frame_start,
  input  logic [9:0] pixel_x,
  input  logic [8:0] pixel_y,
  input  logic [7:0] chan_0,
  input  logic [7:0] chan_1,
  input  logic [7:0] chan_2,
  input  logic [9:0] box_left,
  input  logic [9:0] box_right,
  input  logic [8:0] box_top,
  input  logic [8:0] box_bottom,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] bkg_0,
  output logic [7:0] bkg_1,
  output logic [7:0] bkg_2,
  output logic [15:0] sample_count,
  output logic       inside_box
);

  typedef struct packed {
    logic                        valid;
    logic [rabm_pkg::ADDR_W-1:0] addr;
    logic                        on_frame;
    logic                        in_box;
    logic                        kind;
    rabm_pkg::rgb_t              pix;
    logic [31:0]                 fc;
  } s1_t;

  logic [9:0]                  diff_threshold;
  logic [31:0]                 frame_counter;
  logic [31:0]                 fc_next;
  logic                        adv;
  logic                        accept;
  logic                        hit_div;
  logic                        hit_s1;
  logic                        on_frame;
  logic                        in_box;
  logic [rabm_pkg::ADDR_W-1:0] addr;
  s1_t                         s1;
  logic [rabm_pkg::MEM_W-1:0]  rdata;
  rabm_pkg::div_stage_t        din;
  rabm_pkg::div_stage_t        dout;
  rabm_pkg::rgb_t              bkg_new;
  logic                        mem_we;

  assign adv = !out_valid || out_ready;

  // threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      diff_threshold <= rabm_pkg::THR_RESET;
    end else if (cfg_we) begin
      diff_threshold <= cfg_wdata;
    end
  end

  // address, frame and box decode
  assign on_frame = (int'(pixel_x) < rabm_pkg::FRAME_WIDTH) &&
                    (int'(pixel_y) < rabm_pkg::FRAME_HEIGHT);
  assign addr     = rabm_pkg::ADDR_W'(int'(pixel_y) * rabm_pkg::FRAME_WIDTH + int'(pixel_x));
  assign in_box   = (pixel_x > box_left) && (pixel_x < box_right) &&
                    (pixel_y > box_top) && (pixel_y < box_bottom);

  // interlock on an entry with a pending write
  assign hit_s1   = s1.valid && (s1.addr == addr);
  assign in_ready = !rst && adv && !hit_s1 && !hit_div;
  assign accept   = in_valid && in_ready;

  // saturating frame counter, bumped before the pixel is processed
  always_comb begin
    fc_next = frame_counter;
    if (kind && frame_start && (frame_counter != '1)) begin
      fc_next = frame_counter + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_counter <= '0;
    end else if (accept) begin
      frame_counter <= fc_next;
    end
  end

  // read stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else if (adv) begin
      s1.valid    <= accept;
      s1.addr     <= addr;
      s1.on_frame <= on_frame;
      s1.in_box   <= in_box;
      s1.kind     <= kind;
      s1.pix      <= {chan_2, chan_1, chan_0};
      s1.fc       <= fc_next;
    end
  end

  rabm_mem #(
    .DATA_W (rabm_pkg::MEM_W),
    .ADDR_W (rabm_pkg::ADDR_W),
    .DEPTH  (rabm_pkg::PIXELS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (dout.side.addr),
    .wdata ({bkg_new, dout.side.cnt}),
    .re    (adv),
    .raddr (addr),
    .rdata (rdata)
  );

  // update decision on the stored entry
  always_comb begin
    rabm_pkg::rgb_t  b;
    rabm_pkg::cnt_t  cnt;
    logic [9:0]      sum;
    logic            below;
    b   = rdata[rabm_pkg::MEM_W-1 -: 24];
    cnt = rdata[rabm_pkg::COUNT_BITS-1:0];
    sum = '0;
    din = '0;
    for (int c = 0; c < 3; c++) begin
      din.side.neg[c] = s1.pix[c] < b[c];
      din.dvd[c] = din.side.neg[c] ? (b[c] - s1.pix[c]) : (s1.pix[c] - b[c]);
      sum = sum + 10'(din.dvd[c]);
    end
    below = sum < diff_threshold;
    din.dvs           = rabm_pkg::DIV_W'(cnt) + rabm_pkg::DIV_W'(1);
    din.side.valid    = s1.valid;
    din.side.addr     = s1.addr;
    din.side.on_frame = s1.on_frame;
    din.side.in_box   = s1.in_box;
    din.side.bkg      = b;
    din.side.cnt      = cnt;
    if (!s1.on_frame) begin
      din.side.bkg = '0;
      din.side.cnt = '0;
    end else if (!s1.kind) begin
      din.side.wr = 1'b1;
      if (s1.in_box) begin
        din.side.bkg = {3{rabm_pkg::GRAY}};
        din.side.cnt = '0;
      end else begin
        din.side.bkg = s1.pix;
        din.side.cnt = rabm_pkg::cnt_t'(1);
      end
    end else if (!s1.in_box) begin
      if (below && (cnt != '0)) begin
        din.side.wr  = 1'b1;
        din.side.avg = 1'b1;
        if (cnt != rabm_pkg::COUNT_MAX) begin
          din.side.cnt = cnt + rabm_pkg::cnt_t'(1);
        end
      end else if (below || (cnt == '0) ||
                   ({1'b0, cnt, 1'b0} < (rabm_pkg::COUNT_BITS+2)'(s1.fc)) ||
                   (s1.fc[31:(rabm_pkg::COUNT_BITS+1 > 31 ? 31 : rabm_pkg::COUNT_BITS+1)] != '0
                    && rabm_pkg::COUNT_BITS < 31)) begin
        din.side.wr  = 1'b1;
        din.side.bkg = s1.pix;
        din.side.cnt = rabm_pkg::cnt_t'(1);
      end
    end
  end

  rabm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .din      (din),
    .chk_addr (addr),
    .hit      (hit_div),
    .dout     (dout)
  );

  // truncated running average: b + (p-b)/(n+1), rounded down
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (!dout.side.avg) begin
        bkg_new[c] = dout.side.bkg[c];
      end else if (dout.side.neg[c]) begin
        bkg_new[c] = dout.side.bkg[c] - dout.quo[c] - 8'(dout.rem[c] != '0);
      end else begin
        bkg_new[c] = dout.side.bkg[c] + dout.quo[c];
      end
    end
  end

  assign mem_we = adv && dout.side.valid && dout.side.wr;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid    <= dout.side.valid;
      bkg_0        <= bkg_new[0];
      bkg_1        <= bkg_new[1];
      bkg_2        <= bkg_new[2];
      sample_count <= 16'(dout.side.cnt);
      inside_box   <= dout.side.in_box;
    end
  end

endmodule

FILE: hdl/rabm_mem.sv
module rabm_mem #(
  parameter int DATA_W = 40,
  parameter int ADDR_W = 19,
  parameter int DEPTH  = 307200
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/rabm_div.sv
module rabm_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       adv,
  input  rabm_pkg::div_stage_t       din,
  input  logic [rabm_pkg::ADDR_W-1:0] chk_addr,
  output logic                       hit,
  output rabm_pkg::div_stage_t       dout
);

  rabm_pkg::div_stage_t st [rabm_pkg::DIV_STEPS+1];
  logic [rabm_pkg::DIV_STEPS:0] stage_hit;

  // entry register
  always_ff @(posedge clk) begin
    if (rst) begin
      st[0].side.valid <= 1'b0;
    end else if (adv) begin
      st[0] <= din;
    end
  end

  // one restoring quotient bit per stage, msb first
  for (genvar k = 1; k <= rabm_pkg::DIV_STEPS; k++) begin : g_step
    rabm_pkg::div_stage_t nxt;
    always_comb begin
      logic [8:0]                  rs;
      logic [rabm_pkg::CMP_W-1:0]  rw;
      logic [rabm_pkg::CMP_W-1:0]  qw;
      nxt = st[k-1];
      qw  = rabm_pkg::CMP_W'(st[k-1].dvs);
      for (int c = 0; c < 3; c++) begin
        rs = {st[k-1].rem[c], st[k-1].dvd[c][rabm_pkg::DIV_STEPS-k]};
        rw = rabm_pkg::CMP_W'(rs);
        if (rw >= qw) begin
          nxt.rem[c] = 8'(rw - qw);
          nxt.quo[c][rabm_pkg::DIV_STEPS-k] = 1'b1;
        end else begin
          nxt.rem[c] = rs[7:0];
        end
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        st[k].side.valid <= 1'b0;
      end else if (adv) begin
        st[k] <= nxt;
      end
    end
  end

  // pending-write address match across all stages
  for (genvar k = 0; k <= rabm_pkg::DIV_STEPS; k++) begin : g_hit
    assign stage_hit[k] = st[k].side.valid && (st[k].side.addr == chk_addr);
  end

  assign hit  = |stage_hit;
  assign dout = st[rabm_pkg::DIV_STEPS];

endmodule

FILE: hdl/rabm_chk.sv
`include "running_average_background_model_macros.svh"

module rabm_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  bkg_0,
  input logic [7:0]  bkg_1,
  input logic [7:0]  bkg_2,
  input logic [15:0] sample_count,
  input logic        inside_box
);

  // reset empties the output register
  `RABM_ASSERT_NEXT(a_rst_empty, clk, 1'b0, rst, !out_valid, "output valid after reset")

  // a stalled result holds
  `RABM_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready,
    out_valid && $stable(bkg_0) && $stable(bkg_1) && $stable(bkg_2) && $stable(sample_count) && $stable(inside_box),
    "stalled result changed")

  // a stalled output freezes the whole pipeline, so no transaction is taken
  `RABM_ASSERT_IMPL(a_stall_blocks, clk, rst, out_valid && !out_ready, !in_ready,
    "input accepted while output stalled")

  // nothing is taken during reset
  `RABM_ASSERT_IMPL(a_rst_ready, clk, 1'b0, rst, !in_ready, "ready during reset")

endmodule

bind running_average_background_model rabm_chk u_chk (.*);

FILE: dv/running_average_background_model_tb.sv
`timescale 1ns / 1ps

module running_average_background_model_tb;

  // one pixel transaction as driven on the input ports
  typedef struct {
    bit        kind;
    bit        fstart;
    bit [9:0]  x;
    bit [8:0]  y;
    bit [7:0]  c0, c1, c2;
    bit [9:0]  bl, br;
    bit [8:0]  bt, bb;
  } pixel_t;

  // background seen on the output ports
  typedef struct {
    bit [7:0]  b0, b1, b2;
    bit [15:0] cnt;
    bit        ins;
  } bkg_t;

  // directed row: a pixel and, where obvious, its known background
  typedef struct {
    pixel_t px;
    bit     known;
    bkg_t   res;
  } dir_row_t;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 20;
  localparam int POOL_SIZE      = 24;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [9:0] cfg_wdata = '0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       kind = 1'b0, frame_start = 1'b0;
  logic [9:0] pixel_x = '0, box_left = '0, box_right = '0;
  logic [8:0] pixel_y = '0, box_top = '0, box_bottom = '0;
  logic [7:0] chan_0 = '0, chan_1 = '0, chan_2 = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] bkg_0, bkg_1, bkg_2;
  logic [15:0] sample_count;
  logic       inside_box;

  running_average_background_model u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .kind(kind), .frame_start(frame_start),
    .pixel_x(pixel_x), .pixel_y(pixel_y), .chan_0(chan_0), .chan_1(chan_1),
    .chan_2(chan_2), .box_left(box_left), .box_right(box_right), .box_top(box_top),
    .box_bottom(box_bottom), .out_valid(out_valid), .out_ready(out_ready),
    .bkg_0(bkg_0), .bkg_1(bkg_1), .bkg_2(bkg_2), .sample_count(sample_count),
    .inside_box(inside_box)
  );

  always #5 clk = ~clk;

  // shadow of the background model
  bit [23:0]   bkg_mem [int];
  int unsigned cnt_mem [int];
  bit [31:0]   frame_ctr;
  bit [9:0]    diff_thr;

  bkg_t expected_bkg_q[$];
  int   errors;
  int   burst_left;
  int   hold_left;
  bit   hold_req, hold_done;
  int   idle_cycles;

  int   pool_x [POOL_SIZE];
  int   pool_y [POOL_SIZE];

  // compute the background after one pixel and update the shadow state
  function automatic bkg_t model_pixel(pixel_t p);
    bkg_t        r;
    bit          ins;
    int          idx;
    int unsigned cnt, sum;
    bit [7:0]    bg [3];
    bit [7:0]    pc [3];
    longint unsigned acc;
    ins = p.x > p.bl && p.x < p.br && p.y > p.bt && p.y < p.bb;
    if (p.kind && p.fstart && frame_ctr != 32'hFFFF_FFFF) frame_ctr++;
    r = '{default: 0};
    r.ins = ins;
    if (p.x >= rabm_pkg::FRAME_WIDTH || p.y >= rabm_pkg::FRAME_HEIGHT) return r;
    idx = p.y * rabm_pkg::FRAME_WIDTH + p.x;
    cnt = cnt_mem.exists(idx) ? cnt_mem[idx] : 0;
    {bg[2], bg[1], bg[0]} = bkg_mem.exists(idx) ? bkg_mem[idx] : 24'd0;
    pc[0] = p.c0; pc[1] = p.c1; pc[2] = p.c2;
    if (!p.kind) begin
      if (ins) begin
        bkg_mem[idx] = {3{rabm_pkg::GRAY}};
        cnt_mem[idx] = 0;
      end else begin
        bkg_mem[idx] = {p.c2, p.c1, p.c0};
        cnt_mem[idx] = 1;
      end
    end else if (!ins) begin
      sum = 0;
      for (int c = 0; c < 3; c++) sum += (pc[c] > bg[c]) ? pc[c] - bg[c] : bg[c] - pc[c];
      if (sum < diff_thr) begin
        if (cnt == 0) begin
          bkg_mem[idx] = {p.c2, p.c1, p.c0};
          cnt_mem[idx] = 1;
        end else begin
          for (int c = 0; c < 3; c++) begin
            acc = longint'(bg[c]) * cnt + pc[c];
            bg[c] = acc / (cnt + 1);
          end
          bkg_mem[idx] = {bg[2], bg[1], bg[0]};
          if (cnt < 65535) cnt_mem[idx] = cnt + 1;
        end
      end else if (cnt == 0 || 2 * longint'(cnt) < longint'(frame_ctr)) begin
        bkg_mem[idx] = {p.c2, p.c1, p.c0};
        cnt_mem[idx] = 1;
      end
    end
    {r.b2, r.b1, r.b0} = bkg_mem[idx];
    r.cnt = cnt_mem[idx][15:0];
    return r;
  endfunction

  // drive one pixel transaction, then idle per the burst pattern
  task automatic send_pixel(pixel_t p, bit known, bkg_t res);
    bkg_t pred;
    int   gap;
    @(negedge clk);
    kind <= p.kind; frame_start <= p.fstart; pixel_x <= p.x; pixel_y <= p.y;
    chan_0 <= p.c0; chan_1 <= p.c1; chan_2 <= p.c2;
    box_left <= p.bl; box_right <= p.br; box_top <= p.bt; box_bottom <= p.bb;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    pred = model_pixel(p);
    expected_bkg_q.push_back(known ? res : pred);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 6);
      burst_left = $urandom_range(0, 20);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // wait for every expected background, then let the pipeline settle
  task automatic drain_pixels();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_bkg_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(bit [9:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    diff_thr = v;
  endtask

  function automatic pixel_t rand_box(pixel_t p);
    if ($urandom_range(0, 3) == 0) begin
      p.bl = $urandom; p.br = $urandom; p.bt = $urandom; p.bb = $urandom;
    end else begin
      // box that can never contain a pixel
      p.bl = 10'd640; p.br = 10'd0; p.bt = $urandom; p.bb = $urandom;
    end
    return p;
  endfunction

  function automatic bit [7:0] near(bit [7:0] v, int spread);
    int t;
    t = int'(v) + $urandom_range(0, 2 * spread) - spread;
    return (t < 0) ? 8'd0 : (t > 255) ? 8'd255 : t[7:0];
  endfunction

  // random pixel: mostly updates on initialized positions, some noise
  function automatic pixel_t rand_pixel();
    pixel_t p;
    int     k, idx, sel;
    bit [7:0] bg [3];
    p = '{default: 0};
    sel = $urandom_range(0, 19);
    if (sel == 0) begin
      // off the frame
      p.kind = $urandom; p.fstart = $urandom;
      p.x = $urandom_range(0, 1) ? $urandom_range(640, 1023) : $urandom_range(0, 639);
      p.y = (p.x >= 640) ? $urandom_range(0, 511) : $urandom_range(480, 511);
      p.c0 = $urandom; p.c1 = $urandom; p.c2 = $urandom;
      p.bl = $urandom; p.br = $urandom; p.bt = $urandom; p.bb = $urandom;
      return p;
    end
    k = $urandom_range(0, POOL_SIZE - 1);
    p.x = pool_x[k]; p.y = pool_y[k];
    p = rand_box(p);
    if (sel == 1) begin
      // re-init of a known position
      p.kind = 1'b0;
      p.c0 = $urandom; p.c1 = $urandom; p.c2 = $urandom;
      return p;
    end
    p.kind = 1'b1;
    p.fstart = ($urandom_range(0, 3) == 0);
    idx = p.y * rabm_pkg::FRAME_WIDTH + p.x;
    {bg[2], bg[1], bg[0]} = bkg_mem[idx];
    if (sel < 14) begin
      p.c0 = near(bg[0], 40); p.c1 = near(bg[1], 40); p.c2 = near(bg[2], 40);
    end else begin
      p.c0 = $urandom; p.c1 = $urandom; p.c2 = $urandom;
    end
    return p;
  endfunction

  // receiver: random stalls, ready stretches, and one long hold-off
  int  ready_mode_left;
  bit  ready_mode;
  always @(negedge clk) begin
    if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (ready_mode_left == 0) begin
        ready_mode = $urandom;
        ready_mode_left = $urandom_range(10, 80);
      end else begin
        ready_mode_left--;
      end
      out_ready <= ready_mode ? 1'b1 : ($urandom_range(0, 2) != 0);
    end
  end

  // compare each background transaction with the oldest prediction
  always @(posedge clk) begin
    bkg_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_bkg_q.size() == 0) begin
        $display("%0t: unexpected transaction bkg=%0d,%0d,%0d cnt=%0d ins=%0d", $time,
                 bkg_0, bkg_1, bkg_2, sample_count, inside_box);
        errors++;
      end else begin
        e = expected_bkg_q.pop_front();
        if (bkg_0 !== e.b0) begin
          $display("%0t: bkg_0 expected %0d actual %0d", $time, e.b0, bkg_0); errors++;
        end
        if (bkg_1 !== e.b1) begin
          $display("%0t: bkg_1 expected %0d actual %0d", $time, e.b1, bkg_1); errors++;
        end
        if (bkg_2 !== e.b2) begin
          $display("%0t: bkg_2 expected %0d actual %0d", $time, e.b2, bkg_2); errors++;
        end
        if (sample_count !== e.cnt) begin
          $display("%0t: sample_count expected %0d actual %0d", $time, e.cnt, sample_count);
          errors++;
        end
        if (inside_box !== e.ins) begin
          $display("%0t: inside_box expected %0d actual %0d", $time, e.ins, inside_box);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("** running_average_background_model: FAILED **");
      $finish;
    end
  end

  dir_row_t dir_rows [$];

  function automatic dir_row_t mk_row(bit kd, bit fs, int x, int y, int c0, int c1, int c2,
                                      int bl, int br, int bt, int bb, bit known,
                                      int r0, int r1, int r2, int rc, bit ri);
    dir_row_t d;
    d.px = '{kd, fs, x, y, c0, c1, c2, bl, br, bt, bb};
    d.known = known;
    d.res = '{r0, r1, r2, rc, ri};
    return d;
  endfunction

  initial begin
    pixel_t p;
    bit [9:0] thr_list [4];
    errors = 0; burst_left = 0; hold_left = 0; idle_cycles = 0;
    ready_mode_left = 0; ready_mode = 1'b1;
    frame_ctr = '0;
    diff_thr = rabm_pkg::THR_RESET;

    // directed rows
    dir_rows.push_back(mk_row(0, 0, 0, 0, 0, 0, 0, 640, 0, 0, 0, 1, 0, 0, 0, 1, 0));
    dir_rows.push_back(mk_row(0, 0, 639, 479, 255, 255, 255, 640, 0, 0, 0,
                              1, 255, 255, 255, 1, 0));
    dir_rows.push_back(mk_row(0, 1, 5, 5, 77, 88, 99, 0, 640, 0, 480,
                              1, 128, 128, 128, 0, 1));
    dir_rows.push_back(mk_row(1, 1, 640, 0, 1, 2, 3, 640, 0, 0, 0, 1, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(0, 0, 1023, 511, 255, 255, 255, 0, 1023, 0, 511,
                              1, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(1, 1, 5, 5, 10, 20, 30, 640, 0, 0, 0, 1, 10, 20, 30, 1, 0));
    dir_rows.push_back(mk_row(1, 0, 0, 0, 3, 3, 3, 640, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(1, 0, 639, 479, 0, 0, 0, 640, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(1, 0, 639, 479, 0, 0, 0, 600, 640, 400, 480,
                              0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(1, 1, 0, 0, 9, 0, 255, 640, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(1, 1, 5, 5, 12, 22, 28, 640, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(1, 1, 639, 479, 250, 250, 250, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(1, 0, 0, 0, 255, 255, 255, 640, 0, 0, 0, 0, 0, 0, 0, 0, 0));

    // random positions, corners included
    pool_x[0] = 0;   pool_y[0] = 0;
    pool_x[1] = 639; pool_y[1] = 479;
    pool_x[2] = 0;   pool_y[2] = 479;
    pool_x[3] = 639; pool_y[3] = 0;
    for (int i = 4; i < POOL_SIZE; i++) begin
      pool_x[i] = $urandom_range(0, 639);
      pool_y[i] = $urandom_range(0, 479);
    end
    thr_list[0] = 10'd0;
    thr_list[1] = 10'd765;
    thr_list[2] = 10'd511;
    thr_list[3] = $urandom_range(1, 764);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part under the reset threshold
    foreach (dir_rows[i]) send_pixel(dir_rows[i].px, dir_rows[i].known, dir_rows[i].res);

    // random phases, one per threshold setting
    for (int ph = 0; ph < 5; ph++) begin
      drain_pixels();
      if (ph > 0) write_threshold(thr_list[ph - 1]);
      for (int k = 0; k < POOL_SIZE; k++) begin
        p = '{default: 0};
        p.x = pool_x[k]; p.y = pool_y[k];
        p.c0 = $urandom; p.c1 = $urandom; p.c2 = $urandom;
        p = rand_box(p);
        send_pixel(p, 1'b0, '{default: 0});
      end
      for (int n = 0; n < 80; n++) begin
        if (ph == 1 && n == 20) hold_req = 1'b1;
        send_pixel(rand_pixel(), 1'b0, '{default: 0});
      end
    end

    drain_pixels();
    if (errors == 0) begin
      $display("** running_average_background_model: PASSED **");
    end else begin
      $display("** running_average_background_model: FAILED **");
    end
    $finish;
  end

endmodule
